/* hw/rtl/accc_pkg.sv */
// shared constants and controller command type for the contingency counter
// no dependencies; imported by every module of the block
package accc_pkg;

  // default table dimensions
  localparam int unsigned DefMaxValues  = 16;
  localparam int unsigned DefMaxClasses = 8;
  localparam int unsigned DefKeyBits    = 16;
  localparam int unsigned DefCountBits  = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch an accepted beat
    logic search;  // value key match and row read
    logic update;  // class match, count update, result capture
  } accc_cmd_t;

endpackage

/* hw/rtl/accc_ctrl.sv */
// sequencing state machine: accept, search, update
// depends on accc_pkg for the command struct
module accc_ctrl import accc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output accc_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q;
  logic       accept;

  // a new beat may enter while the previous one is in its update cycle
  assign accept = start_i && (state_q != StSearch);
  assign busy_o = (state_q == StSearch);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StSearch;
      end
      StSearch: begin
        state_d = StUpdate;
      end
      StUpdate: begin
        state_d = accept ? StSearch : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StUpdate);
    end
  end

  assign done_o       = done_q;
  assign cmd_o.load   = accept;
  assign cmd_o.search = (state_q == StSearch);
  assign cmd_o.update = (state_q == StUpdate);

endmodule

/* hw/rtl/accc_datapath.sv */
// key tables, row memories, count update and result registers
// depends on accc_pkg for the command struct
module accc_datapath import accc_pkg::*; #(
  parameter int unsigned MAX_VALUES  = DefMaxValues,
  parameter int unsigned MAX_CLASSES = DefMaxClasses,
  parameter int unsigned KEY_BITS    = DefKeyBits,
  parameter int unsigned COUNT_BITS  = DefCountBits,
  localparam int unsigned SlotW  = $clog2(MAX_VALUES),
  localparam int unsigned CSlotW = $clog2(MAX_CLASSES),
  localparam int unsigned DistW  = $clog2(MAX_VALUES + 1),
  localparam int unsigned CCntW  = $clog2(MAX_CLASSES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  accc_cmd_t             cmd_i,
  input  logic [KEY_BITS-1:0]   attr_key_i,
  input  logic [KEY_BITS-1:0]   class_key_i,
  input  logic                  clear_table_i,
  output logic [SlotW-1:0]      value_slot_o,
  output logic [CSlotW-1:0]     class_slot_o,
  output logic [COUNT_BITS-1:0] value_count_o,
  output logic [COUNT_BITS-1:0] pair_count_o,
  output logic                  new_value_o,
  output logic                  new_class_o,
  output logic                  table_full_o,
  output logic [DistW-1:0]      distinct_values_o
);

  typedef logic [MAX_CLASSES-1:0][KEY_BITS-1:0]   key_row_t;
  typedef logic [MAX_CLASSES-1:0][COUNT_BITS-1:0] cnt_row_t;

  // latched beat
  logic [KEY_BITS-1:0] attr_q, class_q;

  // value table, compared in parallel
  logic [KEY_BITS-1:0]   vkey_q   [MAX_VALUES];
  logic [COUNT_BITS-1:0] vcnt_q   [MAX_VALUES];
  logic [CCntW-1:0]      cused_q  [MAX_VALUES];
  logic [DistW-1:0]      in_use_q;

  // per-value class rows
  key_row_t class_mem [MAX_VALUES];
  cnt_row_t pair_mem  [MAX_VALUES];
  key_row_t crow_q;
  cnt_row_t prow_q;

  // search stage
  logic [MAX_VALUES-1:0] vhit;
  logic [SlotW-1:0]      venc, vslot_s, vslot_q;
  logic                  vfound_s, vfull_s, vfound_q, vfull_q;

  // update stage
  logic [MAX_CLASSES-1:0] chit;
  logic [CSlotW-1:0]      cenc, cslot;
  logic [CCntW-1:0]       ncls;
  logic                   cfound, cfull, store;
  logic [COUNT_BITS-1:0]  vcnt_old, vcnt_new, pcnt_old, pcnt_new;
  key_row_t               crow_new;
  cnt_row_t               prow_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      attr_q  <= attr_key_i;
      class_q <= class_key_i;
    end
  end

  // ---- search: match value keys among live slots
  always_comb begin
    for (int i = 0; i < MAX_VALUES; i++) begin
      vhit[i] = (DistW'(i) < in_use_q) && (vkey_q[i] == attr_q);
    end
    venc = '0;
    for (int i = MAX_VALUES - 1; i >= 0; i--) begin
      if (vhit[i]) venc = SlotW'(i);
    end
  end

  assign vfound_s = |vhit;
  assign vfull_s  = !vfound_s && (in_use_q == DistW'(MAX_VALUES));
  assign vslot_s  = vfound_s ? venc : (vfull_s ? '0 : in_use_q[SlotW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      vslot_q  <= vslot_s;
      vfound_q <= vfound_s;
      vfull_q  <= vfull_s;
      crow_q   <= class_mem[vslot_s];
      prow_q   <= pair_mem[vslot_s];
    end
  end

  // ---- update: match class keys in the row, bump counts
  assign ncls = vfound_q ? cused_q[vslot_q] : '0;

  always_comb begin
    for (int j = 0; j < MAX_CLASSES; j++) begin
      chit[j] = (CCntW'(j) < ncls) && (crow_q[j] == class_q);
    end
    cenc = '0;
    for (int j = MAX_CLASSES - 1; j >= 0; j--) begin
      if (chit[j]) cenc = CSlotW'(j);
    end
  end

  assign cfound = |chit;
  assign cfull  = !vfull_q && !cfound && (ncls == CCntW'(MAX_CLASSES));
  assign store  = !vfull_q && !cfull;
  assign cslot  = cfound ? cenc : (cfull ? '0 : ncls[CSlotW-1:0]);

  assign vcnt_old = vfound_q ? vcnt_q[vslot_q] : '0;
  assign pcnt_old = cfound ? prow_q[cslot] : '0;
  // saturating increments
  assign vcnt_new = (vcnt_old == '1) ? vcnt_old : COUNT_BITS'(vcnt_old + 1'b1);
  assign pcnt_new = (pcnt_old == '1) ? pcnt_old : COUNT_BITS'(pcnt_old + 1'b1);

  always_comb begin
    crow_new        = crow_q;
    prow_new        = prow_q;
    crow_new[cslot] = class_q;
    prow_new[cslot] = pcnt_new;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && store) begin
      class_mem[vslot_q] <= crow_new;
      pair_mem[vslot_q]  <= prow_new;
      vcnt_q[vslot_q]    <= vcnt_new;
      if (!vfound_q) vkey_q[vslot_q] <= attr_q;
      if (!cfound) cused_q[vslot_q] <= CCntW'(cslot) + CCntW'(1);
    end
  end

  // live value count; a clearing beat wins over the increment of the one before
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (cmd_i.load && clear_table_i) begin
      in_use_q <= '0;
    end else if (cmd_i.update && store && !vfound_q) begin
      in_use_q <= in_use_q + DistW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      value_slot_o      <= vslot_q;
      class_slot_o      <= store ? cslot : '0;
      value_count_o     <= store ? vcnt_new : (vfull_q ? '0 : vcnt_old);
      pair_count_o      <= store ? pcnt_new : '0;
      new_value_o       <= store && !vfound_q;
      new_class_o       <= store && !cfound;
      table_full_o      <= !store;
      distinct_values_o <= in_use_q + DistW'(store && !vfound_q);
    end
  end

endmodule

/* hw/rtl/attribute_class_contingency_counter_unit.sv */
// top level of the attribute-value by class contingency counter
// depends on accc_pkg, accc_ctrl and accc_datapath
//
// usage
// - input beat: attr_key_i, class_key_i, clear_table_i, taken at a rising edge
//   where start_i is high and busy_o is low
// - result beat: value_slot_o .. distinct_values_o, valid for the single cycle
//   in which done_o is high; the receiver cannot stall, so it must take it then
// - clear_table_i drops all slots and counts before the beat is counted
// - an accepted beat moves through the search state, then the update state, then
//   the result register; done_o is registered from the update state, so it
//   rises as the result register is loaded
// - a new beat can enter during the update of the current one; busy_o is high
//   only in the search cycle
// - the search cycle compares all value keys at once and reads that value's
//   class row; the update cycle compares the row and writes counts back
// - reset returns the controller to idle, empties the value table and
//   drops done_o; no clearing pass is needed, keys and counts are only read
//   behind the live slot counts
module attribute_class_contingency_counter_unit import accc_pkg::*; #(
  parameter int unsigned MAX_VALUES  = DefMaxValues,
  parameter int unsigned MAX_CLASSES = DefMaxClasses,
  parameter int unsigned KEY_BITS    = DefKeyBits,
  parameter int unsigned COUNT_BITS  = DefCountBits,
  localparam int unsigned SlotW  = $clog2(MAX_VALUES),
  localparam int unsigned CSlotW = $clog2(MAX_CLASSES),
  localparam int unsigned DistW  = $clog2(MAX_VALUES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input beat
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [KEY_BITS-1:0]   attr_key_i,
  input  logic [KEY_BITS-1:0]   class_key_i,
  input  logic                  clear_table_i,
  // result beat
  output logic                  done_o,
  output logic [SlotW-1:0]      value_slot_o,
  output logic [CSlotW-1:0]     class_slot_o,
  output logic [COUNT_BITS-1:0] value_count_o,
  output logic [COUNT_BITS-1:0] pair_count_o,
  output logic                  new_value_o,
  output logic                  new_class_o,
  output logic                  table_full_o,
  output logic [DistW-1:0]      distinct_values_o
);

  accc_cmd_t cmd;

  // sequencer
  accc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // tables and count arithmetic
  accc_datapath #(
    .MAX_VALUES  (MAX_VALUES),
    .MAX_CLASSES (MAX_CLASSES),
    .KEY_BITS    (KEY_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .attr_key_i        (attr_key_i),
    .class_key_i       (class_key_i),
    .clear_table_i     (clear_table_i),
    .value_slot_o      (value_slot_o),
    .class_slot_o      (class_slot_o),
    .value_count_o     (value_count_o),
    .pair_count_o      (pair_count_o),
    .new_value_o       (new_value_o),
    .new_class_o       (new_class_o),
    .table_full_o      (table_full_o),
    .distinct_values_o (distinct_values_o)
  );

endmodule

/* hw/rtl/accc_checker.sv */
// port-level checks for the contingency counter, bound to the top level
// depends on accc_pkg and attribute_class_contingency_counter_unit
module accc_checker import accc_pkg::*; #(
  parameter int unsigned MAX_VALUES  = DefMaxValues,
  parameter int unsigned COUNT_BITS  = DefCountBits,
  localparam int unsigned DistW = $clog2(MAX_VALUES + 1)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  done_o,
  input logic [COUNT_BITS-1:0] pair_count_o,
  input logic                  new_value_o,
  input logic                  new_class_o,
  input logic                  table_full_o,
  input logic [DistW-1:0]      distinct_values_o
);

  // an accepted beat always produces a result
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("accepted beat produced no result");

  // busy covers only the single search cycle
  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  // result strobes are never back to back
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // a rejected beat stores nothing
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (!new_value_o && !new_class_o && pair_count_o == '0))
    else $error("full result reports a stored entry");

  // a counted beat has a nonzero pair count and at least one live value
  a_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !table_full_o) |-> (pair_count_o != '0 && distinct_values_o != '0))
    else $error("counted beat with empty count");

endmodule

bind attribute_class_contingency_counter_unit accc_checker #(
  .MAX_VALUES (MAX_VALUES),
  .COUNT_BITS (COUNT_BITS)
) u_accc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .pair_count_o      (pair_count_o),
  .new_value_o       (new_value_o),
  .new_class_o       (new_class_o),
  .table_full_o      (table_full_o),
  .distinct_values_o (distinct_values_o)
);

/* verif/attribute_class_contingency_counter_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for attribute_class_contingency_counter_unit: a queue-fed driver,
// a monitor holding its own copy of the count table, and a field-by-field result check
// depends on accc_pkg and the top level of the block
module attribute_class_contingency_counter_unit_tb import accc_pkg::*;;

  localparam int unsigned MaxValues  = DefMaxValues;
  localparam int unsigned MaxClasses = DefMaxClasses;
  localparam int unsigned KeyBits    = DefKeyBits;
  localparam int unsigned CountBits  = DefCountBits;
  localparam int unsigned SlotW      = $clog2(MaxValues);
  localparam int unsigned CSlotW     = $clog2(MaxClasses);
  localparam int unsigned DistW      = $clog2(MaxValues + 1);
  // upper bound for the watchdog; a correct run ends well before it
  localparam int unsigned CycleLimit = 1_000_000;

  // one example as offered to the block
  typedef struct {
    logic [KeyBits-1:0] attr;
    logic [KeyBits-1:0] cls;
    logic               clr;
  } example_t;

  // one result beat as the block should report it
  typedef struct packed {
    logic [SlotW-1:0]     value_slot;
    logic [CSlotW-1:0]    class_slot;
    logic [CountBits-1:0] value_count;
    logic [CountBits-1:0] pair_count;
    logic                 new_value;
    logic                 new_class;
    logic                 table_full;
    logic [DistW-1:0]     distinct_values;
  } tally_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [KeyBits-1:0]   attr_key_i = '0;
  logic [KeyBits-1:0]   class_key_i = '0;
  logic                 clear_table_i = 1'b0;
  logic                 done_o;
  logic [SlotW-1:0]     value_slot_o;
  logic [CSlotW-1:0]    class_slot_o;
  logic [CountBits-1:0] value_count_o;
  logic [CountBits-1:0] pair_count_o;
  logic                 new_value_o;
  logic                 new_class_o;
  logic                 table_full_o;
  logic [DistW-1:0]     distinct_values_o;

  attribute_class_contingency_counter_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .attr_key_i        (attr_key_i),
    .class_key_i       (class_key_i),
    .clear_table_i     (clear_table_i),
    .done_o            (done_o),
    .value_slot_o      (value_slot_o),
    .class_slot_o      (class_slot_o),
    .value_count_o     (value_count_o),
    .pair_count_o      (pair_count_o),
    .new_value_o       (new_value_o),
    .new_class_o       (new_class_o),
    .table_full_o      (table_full_o),
    .distinct_values_o (distinct_values_o)
  );

  // examples still to be offered, and predicted results still to arrive
  example_t example_q[$];
  tally_t   predicted_tallies[$];

  // sender idle chance in percent, changed per phase
  int unsigned idle_pct = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  // predicted count table
  logic [KeyBits-1:0]   val_key  [MaxValues];
  logic [CountBits-1:0] val_cnt  [MaxValues];
  logic [KeyBits-1:0]   cls_key  [MaxValues][MaxClasses];
  logic [CountBits-1:0] pair_cnt [MaxValues][MaxClasses];
  int unsigned          cls_used [MaxValues];
  int unsigned          vals_used;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // keys stay as they are on a clear; only the in-use counts and the counts drop
  function automatic void wipe_table();
    int unsigned i;
    int unsigned j;
    for (i = 0; i < MaxValues; i++) begin
      val_cnt[i]  = '0;
      cls_used[i] = 0;
      for (j = 0; j < MaxClasses; j++) pair_cnt[i][j] = '0;
    end
    vals_used = 0;
  endfunction

  function automatic logic [CountBits-1:0] sat_bump(logic [CountBits-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // count one example into the predicted table and return its result beat
  function automatic tally_t tally_example(logic [KeyBits-1:0] akey,
                                           logic [KeyBits-1:0] ckey, logic clr);
    tally_t      r;
    int unsigned i;
    int unsigned vslot;
    int unsigned cslot;
    int unsigned nclass;
    bit          vfound;
    bit          cfound;
    r      = '0;
    vslot  = 0;
    cslot  = 0;
    vfound = 1'b0;
    cfound = 1'b0;
    if (clr) wipe_table();
    // only live slots are searched, so no stale key is ever compared
    for (i = 0; i < vals_used; i++) begin
      if (!vfound && val_key[i] == akey) begin
        vfound = 1'b1;
        vslot  = i;
      end
    end
    if (!vfound && vals_used >= MaxValues) begin
      // value table full: all slot and count fields stay zero
      r.table_full = 1'b1;
    end else begin
      if (!vfound) begin
        vslot       = vals_used;
        r.new_value = 1'b1;
      end
      nclass = r.new_value ? 0 : cls_used[vslot];
      for (i = 0; i < nclass; i++) begin
        if (!cfound && cls_key[vslot][i] == ckey) begin
          cfound = 1'b1;
          cslot  = i;
        end
      end
      if (!cfound && nclass >= MaxClasses) begin
        // class list full: nothing stored, value count reported unchanged
        r.table_full  = 1'b1;
        r.value_slot  = SlotW'(vslot);
        r.value_count = val_cnt[vslot];
      end else begin
        if (r.new_value) begin
          val_key[vslot]  = akey;
          val_cnt[vslot]  = '0;
          cls_used[vslot] = 0;
          vals_used++;
        end
        if (!cfound) begin
          cslot                  = r.new_value ? 0 : nclass;
          cls_key[vslot][cslot]  = ckey;
          pair_cnt[vslot][cslot] = '0;
          cls_used[vslot]        = cslot + 1;
          r.new_class            = 1'b1;
        end
        val_cnt[vslot]         = sat_bump(val_cnt[vslot]);
        pair_cnt[vslot][cslot] = sat_bump(pair_cnt[vslot][cslot]);
        r.value_slot           = SlotW'(vslot);
        r.class_slot           = CSlotW'(cslot);
        r.value_count          = val_cnt[vslot];
        r.pair_count           = pair_cnt[vslot][cslot];
      end
    end
    r.distinct_values = DistW'(vals_used);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result error at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
    error_cnt++;
  endtask

  task automatic queue_example(logic [KeyBits-1:0] a, logic [KeyBits-1:0] c, logic clr);
    example_t ex;
    ex.attr = a;
    ex.cls  = c;
    ex.clr  = clr;
    example_q.push_back(ex);
  endtask

  // mostly random keys, with the all-zero and all-one codes showing up often
  function automatic logic [KeyBits-1:0] random_key();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return KeyBits'($urandom());
  endfunction

  // runs of examples drawn from small key pools so that slots get reused and
  // tables fill up; some runs skip the opening clear, some items are pure noise
  task automatic queue_random_examples(int unsigned n);
    logic [KeyBits-1:0] vpool[$];
    logic [KeyBits-1:0] cpool[$];
    int unsigned added;
    int unsigned kind;
    int unsigned run;
    int unsigned nv;
    int unsigned nc;
    int unsigned k;
    logic clr;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        queue_example(KeyBits'($urandom()), KeyBits'($urandom()), $urandom_range(7) == 0);
        added++;
      end else begin
        nv = $urandom_range(18, 1);
        nc = $urandom_range(10, 1);
        vpool.delete();
        cpool.delete();
        for (k = 0; k < nv; k++) vpool.push_back(random_key());
        for (k = 0; k < nc; k++) cpool.push_back(random_key());
        run = $urandom_range(60, 4);
        for (k = 0; k < run; k++) begin
          // kind 1 keeps counting on top of whatever table is left over
          clr = (k == 0) ? (kind != 1) : ($urandom_range(49) == 0);
          queue_example(vpool[$urandom_range(nv - 1)], cpool[$urandom_range(nc - 1)], clr);
        end
        added += run;
      end
    end
  endtask

  // wait until every queued example has been taken by the block
  task automatic drain_examples();
    while (example_q.size() != 0 || start_i) @(posedge clk_i);
  endtask

  // driver: holds a beat until it is taken, then offers the next or idles
  always @(posedge clk_i) begin
    example_t nxt;
    bit       holding;
    holding = start_i && busy_o;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!holding) begin
      if (example_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt           = example_q.pop_front();
        start_i       <= 1'b1;
        attr_key_i    <= nxt.attr;
        class_key_i   <= nxt.cls;
        clear_table_i <= nxt.clr;
      end else begin
        // idle cycle: junk on the data lines, start low
        start_i       <= 1'b0;
        attr_key_i    <= KeyBits'($urandom());
        class_key_i   <= KeyBits'($urandom());
        clear_table_i <= 1'(($urandom_range(1)));
      end
    end
  end

  // monitor: check a finished beat first, then predict for a beat taken at this edge
  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (predicted_tallies.size() == 0) begin
          report_mismatch("unexpected result, value_slot", 32'(value_slot_o), '0);
        end else begin
          want = predicted_tallies.pop_front();
          if (value_slot_o !== want.value_slot)
            report_mismatch("value_slot", 32'(value_slot_o), 32'(want.value_slot));
          if (class_slot_o !== want.class_slot)
            report_mismatch("class_slot", 32'(class_slot_o), 32'(want.class_slot));
          if (value_count_o !== want.value_count)
            report_mismatch("value_count", 32'(value_count_o), 32'(want.value_count));
          if (pair_count_o !== want.pair_count)
            report_mismatch("pair_count", 32'(pair_count_o), 32'(want.pair_count));
          if (new_value_o !== want.new_value)
            report_mismatch("new_value", 32'(new_value_o), 32'(want.new_value));
          if (new_class_o !== want.new_class)
            report_mismatch("new_class", 32'(new_class_o), 32'(want.new_class));
          if (table_full_o !== want.table_full)
            report_mismatch("table_full", 32'(table_full_o), 32'(want.table_full));
          if (distinct_values_o !== want.distinct_values)
            report_mismatch("distinct_values", 32'(distinct_values_o),
                            32'(want.distinct_values));
        end
      end
      if (start_i && !busy_o)
        predicted_tallies.push_back(tally_example(attr_key_i, class_key_i, clear_table_i));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("attribute_class_contingency_counter_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    wipe_table();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase 1: sender idles now and then
    idle_pct = 9;
    // extreme keys, new value, new class, existing pair
    queue_example('0, '0, 1'b1);
    queue_example('1, '1, 1'b0);
    queue_example('0, '1, 1'b0);
    queue_example('0, '0, 1'b0);
    // fill one class list, then one class too many, then an existing class
    for (k = 0; k < MaxClasses; k++) queue_example(16'h5a5a, KeyBits'(k * 16'h1111), 1'b0);
    queue_example(16'h5a5a, 16'h1234, 1'b0);
    queue_example(16'h5a5a, 16'h3333, 1'b0);
    // fill the value table, then one value too many, then a known value
    for (k = 3; k < MaxValues; k++) queue_example(KeyBits'(16'h1000 + k), 16'ha5a5, 1'b0);
    queue_example(16'h7777, 16'h0001, 1'b0);
    queue_example('1, '1, 1'b0);
    // clear while full
    queue_example(16'h7777, 16'h0001, 1'b1);
    queue_random_examples(400);
    drain_examples();

    // phase 2: sender mostly idle
    idle_pct = 82;
    queue_random_examples(400);
    drain_examples();

    // phase 3: back to back
    idle_pct = 0;
    queue_random_examples(300);
    // a long run on one pair, then a new class for that value
    queue_example(16'h3c3c, 16'hc3c3, 1'b1);
    for (k = 0; k < 40; k++) queue_example(16'h3c3c, 16'hc3c3, 1'b0);
    queue_example(16'h3c3c, 16'h0001, 1'b0);
    drain_examples();

    while (predicted_tallies.size() != 0) @(posedge clk_i);
    // any result arriving during this wait is spurious
    repeat (8) @(posedge clk_i);
    if (error_cnt == 0 && predicted_tallies.size() == 0) begin
      $display("attribute_class_contingency_counter_unit: match");
    end else begin
      $display("attribute_class_contingency_counter_unit: mismatch");
    end
    $finish;
  end

endmodule
